@@ design/fiarf_pkg.sv @@
package fiarf_pkg;

  localparam int REG_COUNT_DEF  = 10;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int PORT_WIDTH     = 32;
  localparam int SLOT_WIDTH     = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CLEAR_KEY      = 90;

  typedef enum logic [3:0] {
    OP_MOV     = 4'd0,
    OP_ADD     = 4'd1,
    OP_SUB     = 4'd2,
    OP_CMP     = 4'd3,
    OP_IMUL    = 4'd4,
    OP_CDQ     = 4'd5,
    OP_IDIV    = 4'd6,
    OP_JE      = 4'd7,
    OP_JNE     = 4'd8,
    OP_JL      = 4'd9,
    OP_JLE     = 4'd10,
    OP_JMP     = 4'd11,
    OP_LOAD    = 4'd12,
    OP_READ    = 4'd13,
    OP_CLRTEST = 4'd14,
    OP_HALT    = 4'd15
  } op_t;

  localparam logic [SLOT_WIDTH-1:0] REG_R0       = 4'd0;
  localparam logic [SLOT_WIDTH-1:0] REG_R1       = 4'd1;
  localparam logic [SLOT_WIDTH-1:0] REG_R3       = 4'd3;
  localparam logic [SLOT_WIDTH-1:0] SLOT_PREV    = 4'd10;
  localparam logic [SLOT_WIDTH-1:0] SLOT_USEPREV = 4'd11;
  localparam logic [SLOT_WIDTH-1:0] SLOT_FIRST   = 4'd12;
  localparam logic [SLOT_WIDTH-1:0] SLOT_SECOND  = 4'd13;
  localparam logic [SLOT_WIDTH-1:0] SLOT_REM     = 4'd14;

  // decoded request as it waits in the queue
  typedef struct packed {
    op_t                   op;
    logic [SLOT_WIDTH-1:0] a_slot;
    logic [SLOT_WIDTH-1:0] b_slot;
    logic                  a_imm;
    logic                  b_imm;
    logic [PORT_WIDTH-1:0] a_val;
    logic [PORT_WIDTH-1:0] b_val;
    logic                  a_reg;
    logic                  b_reg;
    logic                  dest_reg;
    logic                  dest_ok;
  } fiarf_item_t;

endpackage

@@ design/fiarf_if.sv @@
interface fiarf_instr_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic [3:0]         first_slot;
  logic               first_is_immediate;
  logic signed [31:0] first_immediate;
  logic [3:0]         second_slot;
  logic               second_is_immediate;
  logic signed [31:0] second_immediate;

  modport source(output valid, command, first_slot, first_is_immediate, first_immediate,
                 second_slot, second_is_immediate, second_immediate, input ready);
  modport sink(input valid, command, first_slot, first_is_immediate, first_immediate,
               second_slot, second_is_immediate, second_immediate, output ready);
endinterface

interface fiarf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               zero_flag;
  logic               sign_flag;
  logic               overflow_flag;
  logic               carry_flag;
  logic               branch_taken;
  logic               clear_request;
  logic               halted;

  modport source(output valid, value, zero_flag, sign_flag, overflow_flag, carry_flag,
                 branch_taken, clear_request, halted, input ready);
  modport sink(input valid, value, zero_flag, sign_flag, overflow_flag, carry_flag,
               branch_taken, clear_request, halted, output ready);
endinterface

@@ design/fiarf_front.sv @@
module fiarf_front import fiarf_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  fiarf_instr_if.sink instr,
  input  logic        full,
  output logic        push,
  output fiarf_item_t item
);

  localparam logic [SLOT_WIDTH-1:0] REG_LIMIT = SLOT_WIDTH'(REG_COUNT);

  assign instr.ready = !full;
  assign push        = instr.valid && !full;

  always_comb begin
    item.op       = op_t'(instr.command);
    item.a_slot   = instr.first_slot;
    item.b_slot   = instr.second_slot;
    item.a_imm    = instr.first_is_immediate;
    item.b_imm    = instr.second_is_immediate;
    item.a_val    = instr.first_immediate;
    item.b_val    = instr.second_immediate;
    item.a_reg    = instr.first_slot < REG_LIMIT;
    item.b_reg    = instr.second_slot < REG_LIMIT;
    item.dest_reg = !instr.first_is_immediate && (instr.first_slot < REG_LIMIT);
    item.dest_ok  = item.dest_reg ||
                    (!instr.first_is_immediate && instr.first_slot >= SLOT_PREV &&
                     instr.first_slot <= SLOT_REM);
    // fixed register reads go through the first read port
    unique case (item.op)
      OP_CDQ: begin
        item.a_slot = REG_R0;
        item.a_imm  = 1'b0;
        item.a_reg  = 1'b1;
      end
      OP_CLRTEST: begin
        item.a_slot = REG_R3;
        item.a_imm  = 1'b0;
        item.a_reg  = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/fiarf_queue.sv @@
module fiarf_queue import fiarf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  fiarf_item_t push_item,
  input  logic        pop,
  output logic        full,
  output logic        avail,
  output fiarf_item_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fiarf_item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       count;

  assign full  = count == CW'(QUEUE_DEPTH);
  assign avail = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ design/fiarf_back.sv @@
module fiarf_back import fiarf_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  fiarf_item_t head,
  output logic        pop,
  fiarf_result_if.source result
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = $clog2(REG_COUNT);
  localparam int CW = $clog2(W + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_MULW  = 9'b000001000,
    S_DIVRD = 9'b000010000,
    S_DIVLD = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_DIVQ  = 9'b010000000,
    S_DIVR  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [W-1:0]   mem [REG_COUNT];
  logic           vld [REG_COUNT];
  logic [W-1:0]   prev, first, second, remv;
  logic           use_prev;
  logic           zf, sf, of, cf;
  logic           halt;

  fiarf_item_t    cur;
  logic [W-1:0]   rd_a, rd_b;
  logic [RW-1:0]  rd_addr_a, rd_addr_b;
  logic           rd_en;
  logic [W-1:0]   opnd_a, opnd_b;
  logic [2*W-1:0] prod;
  logic [2*W-1:0] dq;
  logic [W-1:0]   drem, dmv;
  logic           dneg_q, dneg_r;
  logic [CW-1:0]  cnt;

  logic           out_valid;
  logic [W-1:0]   o_val;
  logic           o_z, o_s, o_o, o_c, o_taken, o_clr, o_halt;

  logic           out_free, fire;
  logic [W-1:0]   opa, opb, var_a, var_b, sum, dif, ld;
  logic           add_ovf, sub_ovf, mul_ovf;
  logic           we, var_we, flag_we, halt_set;
  logic [RW-1:0]  wa;
  logic [W-1:0]   wd, var_d, res_val, q_fix, r_fix;
  logic           nz, ns, no, nc, res_taken, res_clr;
  logic [W:0]     dr1, dr2, dm1, dm2;
  logic           dg1, dg2;
  logic [2*W-1:0] dq1, dq2, dvd;

  function automatic logic [W-1:0] var_read(input logic [SLOT_WIDTH-1:0] s,
      input logic [W-1:0] p, input logic u, input logic [W-1:0] f,
      input logic [W-1:0] sc, input logic [W-1:0] r);
    logic [W-1:0] v;
    case (s)
      SLOT_PREV:    v = p;
      SLOT_USEPREV: v = W'(u);
      SLOT_FIRST:   v = f;
      SLOT_SECOND:  v = sc;
      SLOT_REM:     v = r;
      default:      v = '0;
    endcase
    return v;
  endfunction

  assign out_free = !out_valid || result.ready;
  assign pop      = (state == S_IDLE) && avail;

  always_comb begin
    var_a   = var_read(cur.a_slot, prev, use_prev, first, second, remv);
    var_b   = var_read(cur.b_slot, prev, use_prev, first, second, remv);
    opa     = cur.a_imm ? cur.a_val[W-1:0] : (cur.a_reg ? rd_a : var_a);
    opb     = cur.b_imm ? cur.b_val[W-1:0] : (cur.b_reg ? rd_b : var_b);
    ld      = cur.b_val[W-1:0];
    sum     = opa + opb;
    dif     = opa - opb;
    add_ovf = ~(opa[W-1] ^ opb[W-1]) & (opa[W-1] ^ sum[W-1]);
    sub_ovf = (opa[W-1] ^ opb[W-1]) & (opa[W-1] ^ dif[W-1]);
    mul_ovf = prod[2*W-1:W-1] != {(W+1){prod[W-1]}};
    q_fix   = dneg_q ? -dq[W-1:0] : dq[W-1:0];
    r_fix   = dneg_r ? -drem : drem;

    // two restoring division steps a cycle
    dr1 = {drem, dq[2*W-1]};
    dg1 = dr1 >= {1'b0, dmv};
    dm1 = dg1 ? dr1 - {1'b0, dmv} : dr1;
    dq1 = {dq[2*W-2:0], dg1};
    dr2 = {dm1[W-1:0], dq1[2*W-1]};
    dg2 = dr2 >= {1'b0, dmv};
    dm2 = dg2 ? dr2 - {1'b0, dmv} : dr2;
    dq2 = {dq1[2*W-2:0], dg2};

    // dividend is sext(R0) or-ed with R1 in the upper half
    dvd = {(rd_a[W-1] ? {W{1'b1}} : rd_b), rd_a};

    rd_en     = pop || (state == S_DIVRD);
    rd_addr_a = (state == S_DIVRD) ? RW'(REG_R0) : head.a_slot[RW-1:0];
    rd_addr_b = (state == S_DIVRD) ? RW'(REG_R1) : head.b_slot[RW-1:0];

    state_next = state;
    fire       = 1'b0;
    we         = 1'b0;
    wa         = cur.a_slot[RW-1:0];
    wd         = opb;
    var_we     = 1'b0;
    var_d      = opb;
    flag_we    = 1'b0;
    nz         = zf;
    ns         = sf;
    no         = of;
    nc         = cf;
    res_val    = '0;
    res_taken  = 1'b0;
    res_clr    = 1'b0;
    halt_set   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (avail) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (halt) begin
          if (out_free) begin
            fire       = 1'b1;
            state_next = S_IDLE;
          end
        end else if (cur.op == OP_IMUL && cur.dest_reg) begin
          state_next = S_MUL;
        end else if (cur.op == OP_IDIV && opa != '0) begin
          state_next = S_DIVRD;
        end else if (out_free) begin
          fire       = 1'b1;
          state_next = S_IDLE;
          unique case (cur.op)
            OP_MOV: begin
              if (cur.dest_ok) begin
                res_val = opb;
                if (cur.dest_reg) begin
                  we      = 1'b1;
                  flag_we = 1'b1;
                  nz      = opb == '0;
                  ns      = opb[W-1];
                end else begin
                  var_we = 1'b1;
                end
              end
            end
            OP_ADD: begin
              if (cur.dest_reg) begin
                we      = 1'b1;
                wd      = sum;
                res_val = sum;
                flag_we = 1'b1;
                nz      = sum == '0;
                ns      = sum[W-1];
                no      = add_ovf;
                nc      = 1'b0;
              end
            end
            OP_SUB: begin
              if (cur.dest_reg) begin
                we      = 1'b1;
                wd      = dif;
                res_val = dif;
                flag_we = 1'b1;
                nz      = dif == '0;
                ns      = dif[W-1];
                no      = sub_ovf;
                nc      = 1'b0;
              end
            end
            OP_CMP: begin
              flag_we = 1'b1;
              nz      = dif == '0;
              ns      = dif[W-1];
              no      = sub_ovf;
              nc      = 1'b0;
            end
            OP_IMUL: begin
            end
            OP_CDQ: begin
              we      = 1'b1;
              wa      = RW'(REG_R1);
              wd      = {W{rd_a[W-1]}};
              res_val = {W{rd_a[W-1]}};
            end
            OP_IDIV: begin
              // divide by zero
              flag_we = 1'b1;
              nz      = 1'b0;
              ns      = 1'b0;
              no      = 1'b1;
              nc      = 1'b1;
            end
            OP_JE:  res_taken = zf;
            OP_JNE: res_taken = !zf;
            OP_JL:  res_taken = sf != of;
            OP_JLE: res_taken = zf || (sf != of);
            OP_JMP: res_taken = 1'b1;
            OP_LOAD: begin
              if (cur.dest_ok) begin
                wd      = ld;
                var_d   = ld;
                we      = cur.dest_reg;
                var_we  = !cur.dest_reg;
                res_val = (cur.a_slot == SLOT_USEPREV) ? W'(ld != '0) : ld;
              end
            end
            OP_READ:    res_val = opa;
            OP_CLRTEST: res_clr = rd_a == W'(CLEAR_KEY);
            OP_HALT:    halt_set = 1'b1;
          endcase
        end
      end
      S_MUL: state_next = S_MULW;
      S_MULW: begin
        if (out_free) begin
          fire       = 1'b1;
          state_next = S_IDLE;
          we         = 1'b1;
          wd         = prod[W-1:0];
          res_val    = prod[W-1:0];
          flag_we    = 1'b1;
          nz         = prod[W-1:0] == '0;
          ns         = prod[W-1];
          no         = mul_ovf;
          nc         = mul_ovf;
        end
      end
      S_DIVRD: state_next = S_DIVLD;
      S_DIVLD: state_next = S_DIV;
      S_DIV: begin
        if (cnt == CW'(1)) state_next = S_DIVQ;
      end
      S_DIVQ: begin
        we         = 1'b1;
        wa         = RW'(REG_R0);
        wd         = q_fix;
        state_next = S_DIVR;
      end
      S_DIVR: begin
        if (out_free) begin
          fire       = 1'b1;
          state_next = S_IDLE;
          we         = 1'b1;
          wa         = RW'(REG_R1);
          wd         = r_fix;
          res_val    = q_fix;
          flag_we    = 1'b1;
          nz         = q_fix == '0;
          ns         = q_fix[W-1];
          no         = 1'b0;
          nc         = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      zf        <= 1'b0;
      sf        <= 1'b0;
      of        <= 1'b0;
      cf        <= 1'b0;
      halt      <= 1'b0;
      use_prev  <= 1'b0;
      prev      <= '0;
      first     <= '0;
      second    <= '0;
      remv      <= '0;
      for (int i = 0; i < REG_COUNT; i++) vld[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (flag_we) begin
        zf <= nz;
        sf <= ns;
        of <= no;
        cf <= nc;
      end
      if (halt_set) halt <= 1'b1;
      if (we) vld[wa] <= 1'b1;
      if (var_we) begin
        case (cur.a_slot)
          SLOT_PREV:    prev     <= var_d;
          SLOT_USEPREV: use_prev <= var_d != '0;
          SLOT_FIRST:   first    <= var_d;
          SLOT_SECOND:  second   <= var_d;
          SLOT_REM:     remv     <= var_d;
          default: begin
          end
        endcase
      end
    end
  end

  // register file: two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) begin
      rd_a <= vld[rd_addr_a] ? mem[rd_addr_a] : '0;
      rd_b <= vld[rd_addr_b] ? mem[rd_addr_b] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (state == S_EXEC) begin
      opnd_a <= opa;
      opnd_b <= opb;
    end
    if (state == S_MUL) prod <= $signed(opnd_a) * $signed(opnd_b);
    if (state == S_DIVLD) begin
      dq     <= dvd[2*W-1] ? -dvd : dvd;
      dmv    <= opnd_a[W-1] ? -opnd_a : opnd_a;
      dneg_q <= dvd[2*W-1] ^ opnd_a[W-1];
      dneg_r <= dvd[2*W-1];
      drem   <= '0;
      cnt    <= CW'(W);
    end
    if (state == S_DIV) begin
      dq   <= dq2;
      drem <= dm2[W-1:0];
      cnt  <= cnt - 1'b1;
    end
    if (fire) begin
      o_val   <= res_val;
      o_z     <= nz;
      o_s     <= ns;
      o_o     <= no;
      o_c     <= nc;
      o_taken <= res_taken;
      o_clr   <= res_clr;
      o_halt  <= halt || halt_set;
    end
  end

  assign result.valid         = out_valid;
  assign result.value         = PORT_WIDTH'($signed(o_val));
  assign result.zero_flag     = o_z;
  assign result.sign_flag     = o_s;
  assign result.overflow_flag = o_o;
  assign result.carry_flag    = o_c;
  assign result.branch_taken  = o_taken;
  assign result.clear_request = o_clr;
  assign result.halted        = o_halt;

endmodule

@@ design/flagged_integer_alu_regfile_top.sv @@
// most instructions pass the queue, S_IDLE and S_EXEC before the registered result; imul to
// a register adds S_MUL and S_MULW, idiv by a nonzero divisor adds S_DIVRD, S_DIVLD, the S_DIV
// loop (two quotient bits a cycle), S_DIVQ and S_DIVR; the execute unit takes one instruction
// at a time, a two-entry queue feeds it
// reset: synchronous, clears registers, variables, flags, halt mark and the queue
module flagged_integer_alu_regfile_top import fiarf_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  fiarf_instr_if.sink    instr,
  fiarf_result_if.source result
);

  logic        full, push, avail, pop;
  fiarf_item_t push_item, head;

  fiarf_front #(.REG_COUNT(REG_COUNT)) u_front (
    .instr (instr),
    .full  (full),
    .push  (push),
    .item  (push_item)
  );

  fiarf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .avail     (avail),
    .head      (head)
  );

  fiarf_back #(.REG_COUNT(REG_COUNT), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (avail),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
